/* hdl/sfl_pkg.sv */
package sfl_pkg;

  // Row geometry
  localparam int ROW_INSTRUCTIONS = 64;
  localparam int ROW_BYTES        = 4 * ROW_INSTRUCTIONS;
  localparam int ADDR_STEP        = 2 * ROW_INSTRUCTIONS;
  localparam int BC_W             = $clog2(ROW_BYTES);

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 24;
  localparam int TICK_W     = 24;
  localparam int RETRY_W    = 4;
  localparam int WIDX_W     = 7;
  localparam int WORD_W     = 16;
  localparam int EV_W       = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Up to three results per input item
  localparam int MAX_RES   = 3;
  localparam int RES_CNT_W = 2;

  // Start pair
  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

  // Configuration reset values
  localparam logic [TICK_W-1:0]  BYTE_TIMEOUT_RST = 24'd6000000;
  localparam logic [TICK_W-1:0]  HS_TIMEOUT_RST   = 24'd6000000;
  localparam logic [ADDR_W-1:0]  START_ADDR_RST   = 24'h000800;
  localparam logic [ADDR_W-1:0]  END_ADDR_RST     = 24'h00ABF6;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST  = 4'd3;

  typedef enum logic [EV_W-1:0] {
    EV_INIT     = 4'd0,
    EV_ERASE    = 4'd1,
    EV_ACK      = 4'd2,
    EV_WRITE    = 4'd3,
    EV_COMMIT   = 4'd4,
    EV_END      = 4'd5,
    EV_PTIMEOUT = 4'd6,
    EV_ERROR    = 4'd7,
    EV_HTIMEOUT = 4'd8
  } sfl_event_e;

  typedef enum logic [1:0] {
    PH_HANDSHAKE = 2'd0,
    PH_LOAD      = 2'd1,
    PH_DONE      = 2'd2
  } sfl_phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTE_TIMEOUT = 3'd0,
    CFG_HS_TIMEOUT   = 3'd1,
    CFG_START_ADDR   = 3'd2,
    CFG_END_ADDR     = 3'd3,
    CFG_RETRY_LIMIT  = 3'd4
  } sfl_cfg_idx_e;

  typedef struct packed {
    logic [TICK_W-1:0]  byte_timeout;
    logic [TICK_W-1:0]  hs_timeout;
    logic [ADDR_W-1:0]  start_addr;
    logic [ADDR_W-1:0]  end_addr;
    logic [RETRY_W-1:0] retry_limit;
  } sfl_cfg_t;

  // All results caused by one input item
  typedef struct packed {
    logic [RES_CNT_W-1:0]         count;
    sfl_event_e [MAX_RES-1:0]     ev;
    logic [ADDR_W-1:0]            addr;
    logic [WIDX_W-1:0]            widx;
    logic [WORD_W-1:0]            word;
  } sfl_bundle_t;

endpackage

/* hdl/sfl_if.sv */
interface sfl_item_if
  import sfl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sfl_result_if
  import sfl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [EV_W-1:0]   event_code;
  logic [ADDR_W-1:0] row_address;
  logic [WIDX_W-1:0] word_index;
  logic [WORD_W-1:0] data_word;
  logic              last;

  modport source (output valid, output event_code, output row_address,
                  output word_index, output data_word, output last, input ready);
  modport sink   (input valid, input event_code, input row_address,
                  input word_index, input data_word, input last, output ready);
endinterface

interface sfl_cfg_if
  import sfl_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/sfl_core.sv */
module sfl_core
  import sfl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfl_cfg_t          cfg_i,
  input  logic              accept_i,
  input  logic              opcode_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              push_o,
  output sfl_bundle_t       bundle_o
);

  sfl_phase_e         phase_q, phase_d;
  logic [BYTE_W-1:0]  prev_q, prev_d;
  logic [TICK_W-1:0]  hs_ticks_q, hs_ticks_d;
  logic [TICK_W-1:0]  idle_q, idle_d;
  logic [BC_W-1:0]    bc_q, bc_d;
  logic [BYTE_W-1:0]  low_q, low_d;
  logic [RETRY_W-1:0] retry_q, retry_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;

  logic [TICK_W-1:0]  hs_inc;
  logic [RETRY_W-1:0] retry_inc;
  logic [ADDR_W:0]    next_addr;
  logic [ADDR_W:0]    reach;

  assign hs_inc    = hs_ticks_q + 1'b1;
  assign retry_inc = retry_q + 1'b1;
  assign next_addr = {1'b0, addr_q} + (ADDR_W+1)'(ADDR_STEP);
  assign reach     = {1'b0, addr_q} + (ADDR_W+1)'(2 * ADDR_STEP - 1);

  always_comb begin
    phase_d    = phase_q;
    prev_d     = prev_q;
    hs_ticks_d = hs_ticks_q;
    idle_d     = idle_q;
    bc_d       = bc_q;
    low_d      = low_q;
    retry_d    = retry_q;
    addr_d     = addr_q;
    bundle_o       = '0;
    bundle_o.addr  = addr_q;
    bundle_o.widx  = WIDX_W'(bc_q >> 1);
    bundle_o.word  = {rx_byte_i, low_q};

    case (phase_q)
      PH_HANDSHAKE: begin
        if (!opcode_i) begin
          hs_ticks_d = hs_inc;
          if (hs_inc >= cfg_i.hs_timeout) begin
            bundle_o.count = 2'd1;
            bundle_o.ev[0] = EV_HTIMEOUT;
            phase_d        = PH_DONE;
          end
        end else if (prev_q == SYNC_FIRST && rx_byte_i == SYNC_SECOND) begin
          bundle_o.count = 2'd3;
          bundle_o.ev[0] = EV_INIT;
          bundle_o.ev[1] = EV_ERASE;
          bundle_o.ev[2] = EV_ACK;
          phase_d        = PH_LOAD;
          bc_d           = '0;
          idle_d         = '0;
          retry_d        = '0;
          addr_d         = cfg_i.start_addr;
        end else begin
          prev_d = rx_byte_i;
        end
      end
      PH_LOAD: begin
        if (!opcode_i) begin
          if (idle_q < cfg_i.byte_timeout) begin
            idle_d = idle_q + 1'b1;
          end else begin
            bc_d           = '0;
            idle_d         = '0;
            retry_d        = retry_inc;
            bundle_o.count = 2'd2;
            bundle_o.ev[0] = EV_PTIMEOUT;
            if (retry_inc >= cfg_i.retry_limit) begin
              bundle_o.ev[1] = EV_ERROR;
              phase_d        = PH_DONE;
            end else begin
              bundle_o.ev[1] = EV_ACK;
            end
          end
        end else begin
          idle_d = '0;
          bc_d   = bc_q + 1'b1;
          if (!bc_q[0]) begin
            low_d = rx_byte_i;
          end else begin
            bundle_o.count = 2'd1;
            bundle_o.ev[0] = EV_WRITE;
            if (bc_q == BC_W'(ROW_BYTES - 1)) begin
              bundle_o.count = 2'd3;
              bundle_o.ev[1] = EV_COMMIT;
              bc_d           = '0;
              retry_d        = '0;
              addr_d         = next_addr[ADDR_W-1:0];
              if (reach > {1'b0, cfg_i.end_addr}) begin
                bundle_o.ev[2] = EV_END;
                phase_d        = PH_DONE;
              end else begin
                bundle_o.ev[2] = EV_ACK;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign push_o = accept_i && (bundle_o.count != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HANDSHAKE;
      prev_q     <= '0;
      hs_ticks_q <= '0;
      idle_q     <= '0;
      bc_q       <= '0;
      low_q      <= '0;
      retry_q    <= '0;
      addr_q     <= START_ADDR_RST;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      prev_q     <= prev_d;
      hs_ticks_q <= hs_ticks_d;
      idle_q     <= idle_d;
      bc_q       <= bc_d;
      low_q      <= low_d;
      retry_q    <= retry_d;
      addr_q     <= addr_d;
    end
  end

endmodule

/* hdl/sfl_out_queue.sv */
module sfl_out_queue
  import sfl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  sfl_bundle_t  bundle_i,
  output logic         space_o,
  sfl_result_if.source result_o
);

  sfl_bundle_t          entry_q [2];
  logic [1:0]           cnt_q, cnt_d;
  logic                 wr_q, rd_q;
  logic [RES_CNT_W-1:0] sub_q, sub_d;

  sfl_bundle_t head;
  sfl_event_e  ev;
  logic        xfer, pop;

  assign head    = entry_q[rd_q];
  assign ev      = head.ev[sub_q];
  assign space_o = (cnt_q != 2'd2);

  assign result_o.valid       = (cnt_q != '0);
  assign result_o.event_code  = ev;
  assign result_o.row_address = (ev == EV_WRITE || ev == EV_COMMIT) ? head.addr : '0;
  assign result_o.word_index  = (ev == EV_WRITE) ? head.widx : '0;
  assign result_o.data_word   = (ev == EV_WRITE) ? head.word : '0;
  assign result_o.last        = (sub_q == head.count - 1'b1);

  assign xfer = result_o.valid && result_o.ready;
  assign pop  = xfer && result_o.last;

  always_comb begin
    sub_d = sub_q;
    if (pop) begin
      sub_d = '0;
    end else if (xfer) begin
      sub_d = sub_q + 1'b1;
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      sub_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sub_q <= sub_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= bundle_i;
    end
  end

endmodule

/* hdl/serial_firmware_load_sequencer.sv */
// An item's results are registered into the result queue when the item is accepted.
// Throughput: one input item per cycle while a result queue entry is free; an item
//   with k results makes k output transfers while the two-entry queue takes new items.
// Input ready drops only while both queue entries are occupied.
// Reset (rst_ni low, asynchronous): handshake phase, all counters cleared,
//   configuration registers back to their default values, result queue emptied.
module serial_firmware_load_sequencer
  import sfl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  sfl_cfg_if.sink      cfg_i,
  sfl_item_if.sink     item_i,
  sfl_result_if.source result_o
);

  // Configuration register file; writes are only expected while idle.
  sfl_cfg_t cfg_q;

  logic        item_accept;
  logic        push;
  logic        space;
  sfl_bundle_t bundle;

  // Configuration writes complete in the cycle they are presented.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.byte_timeout <= BYTE_TIMEOUT_RST;
      cfg_q.hs_timeout   <= HS_TIMEOUT_RST;
      cfg_q.start_addr   <= START_ADDR_RST;
      cfg_q.end_addr     <= END_ADDR_RST;
      cfg_q.retry_limit  <= RETRY_LIMIT_RST;
    end else if (cfg_i.valid) begin
      // Decode the register index; indexes past the list are dropped.
      case (cfg_i.index)
        CFG_BYTE_TIMEOUT: cfg_q.byte_timeout <= cfg_i.data[TICK_W-1:0];
        CFG_HS_TIMEOUT:   cfg_q.hs_timeout   <= cfg_i.data[TICK_W-1:0];
        CFG_START_ADDR:   cfg_q.start_addr   <= cfg_i.data[ADDR_W-1:0];
        CFG_END_ADDR:     cfg_q.end_addr     <= cfg_i.data[ADDR_W-1:0];
        CFG_RETRY_LIMIT:  cfg_q.retry_limit  <= cfg_i.data[RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Accept an item whenever the result queue has a free entry, even while
  // an earlier result still waits at the output.
  assign item_i.ready = space;
  assign item_accept  = item_i.valid && space;

  // Sequencer state and the single-pass decision for each transfer: the
  // state registers advance on the accepted item and its results (zero to
  // three) are captured as one bundle.
  sfl_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (item_accept),
    .opcode_i  (item_i.opcode),
    .rx_byte_i (item_i.rx_byte),
    .push_o    (push),
    .bundle_o  (bundle)
  );

  // Hold bundles and hand out their results one transfer at a time, in order.
  sfl_out_queue u_out_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .space_o  (space),
    .result_o (result_o)
  );

endmodule

/* hdl/sfl_checker.sv */
module sfl_checker
  import sfl_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid,
  input logic              out_ready,
  input logic [EV_W-1:0]   event_code,
  input logic [ADDR_W-1:0] row_address,
  input logic [WIDX_W-1:0] word_index,
  input logic [WORD_W-1:0] data_word,
  input logic              last
);

  logic finished_q;
  logic terminal;

  assign terminal = (event_code == EV_END) || (event_code == EV_ERROR) ||
                    (event_code == EV_HTIMEOUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finished_q <= 1'b0;
    end else if (out_valid && out_ready && last && terminal) begin
      finished_q <= 1'b1;
    end
  end

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(event_code) &&
      $stable(row_address) && $stable(word_index) && $stable(data_word) &&
      $stable(last))
    else $error("result payload changed while stalled");

  // A terminal event closes the result group of its item.
  a_terminal_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && terminal |-> last)
    else $error("terminal event without last");

  // Only word writes carry an index and data.
  a_write_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && event_code != EV_WRITE |-> word_index == '0 && data_word == '0)
    else $error("index or data on a non-write event");

  // Nothing follows once the load has finished.
  a_silent_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> !out_valid)
    else $error("result after end of load");

endmodule

bind serial_firmware_load_sequencer sfl_checker u_sfl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (result_o.valid),
  .out_ready   (result_o.ready),
  .event_code  (result_o.event_code),
  .row_address (result_o.row_address),
  .word_index  (result_o.word_index),
  .data_word   (result_o.data_word),
  .last        (result_o.last)
);

/* test/serial_firmware_load_sequencer_tb.sv */
`timescale 1ns / 100ps

module serial_firmware_load_sequencer_tb;
  import sfl_pkg::*;

  // Input item kinds
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT   = 500;
  // Idle cycles before a register write, and after the last result
  localparam int SETTLE_CYCLES = 3;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 270;
  // Print no more than this many mismatch lines
  localparam int REPORT_LINES  = 100;

  // One result as the sequencer should report it
  typedef struct {
    sfl_event_e        ev;
    logic [ADDR_W-1:0] addr;
    logic [WIDX_W-1:0] widx;
    logic [WORD_W-1:0] word;
    logic              last;
  } load_result_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sfl_cfg_if    cfg_ch ();
  sfl_item_if   item_ch ();
  sfl_result_if result_ch ();

  serial_firmware_load_sequencer DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_ch),
    .item_i   (item_ch),
    .result_o (result_ch)
  );

  // Register copies, at their reset values
  logic [TICK_W-1:0]  cfg_byte_timeout = BYTE_TIMEOUT_RST;
  logic [TICK_W-1:0]  cfg_hs_timeout   = HS_TIMEOUT_RST;
  logic [ADDR_W-1:0]  cfg_start_addr   = START_ADDR_RST;
  logic [ADDR_W-1:0]  cfg_end_addr     = END_ADDR_RST;
  logic [RETRY_W-1:0] cfg_retry_limit  = RETRY_LIMIT_RST;

  // Sequencer state as predicted from the accepted items
  sfl_phase_e         load_phase = PH_HANDSHAKE;
  logic [BYTE_W-1:0]  prev_byte  = '0;
  logic [TICK_W-1:0]  hs_ticks   = '0;
  logic [TICK_W-1:0]  gap_ticks  = '0;
  int unsigned        row_fill   = 0;   // bytes taken into the current row
  logic [BYTE_W-1:0]  held_low   = '0;
  logic [RETRY_W-1:0] retries    = '0;
  logic [ADDR_W-1:0]  row_addr   = START_ADDR_RST;

  load_result_t expected_results[$];

  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          idling_on   = 1'b0;

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= REPORT_LINES) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  function automatic void expect_result(sfl_event_e ev, logic [ADDR_W-1:0] addr,
                                        logic [WIDX_W-1:0] widx, logic [WORD_W-1:0] word);
    load_result_t r;
    r.ev   = ev;
    r.addr = addr;
    r.widx = widx;
    r.word = word;
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  // Advance the predicted state by one accepted item and queue what it causes.
  function automatic void predict_item(logic op, logic [BYTE_W-1:0] b);
    int unsigned queued;
    int unsigned reach;
    queued = expected_results.size();
    case (load_phase)
      PH_HANDSHAKE: begin
        if (op == OP_TICK) begin
          // Ticks accumulate over the whole search; bytes never clear them
          hs_ticks = hs_ticks + 1'b1;
          if (hs_ticks >= cfg_hs_timeout) begin
            expect_result(EV_HTIMEOUT, '0, '0, '0);
            load_phase = PH_DONE;
          end
        end else if (prev_byte == SYNC_FIRST && b == SYNC_SECOND) begin
          expect_result(EV_INIT, '0, '0, '0);
          expect_result(EV_ERASE, '0, '0, '0);
          expect_result(EV_ACK, '0, '0, '0);
          load_phase = PH_LOAD;
          row_fill   = 0;
          gap_ticks  = '0;
          retries    = '0;
          row_addr   = cfg_start_addr;
        end else begin
          prev_byte = b;
        end
      end
      PH_LOAD: begin
        if (op == OP_TICK) begin
          if (gap_ticks < cfg_byte_timeout) begin
            gap_ticks = gap_ticks + 1'b1;
          end else begin
            // Packet timeout: drop the partial row and count a retry
            row_fill  = 0;
            gap_ticks = '0;
            retries   = retries + 1'b1;
            expect_result(EV_PTIMEOUT, '0, '0, '0);
            if (retries >= cfg_retry_limit) begin
              expect_result(EV_ERROR, '0, '0, '0);
              load_phase = PH_DONE;
            end else begin
              expect_result(EV_ACK, '0, '0, '0);
            end
          end
        end else begin
          gap_ticks = '0;
          if ((row_fill % 2) == 0) begin
            held_low = b;
            row_fill++;
          end else begin
            expect_result(EV_WRITE, row_addr, WIDX_W'(row_fill >> 1), {b, held_low});
            row_fill++;
            if (row_fill >= ROW_BYTES) begin
              expect_result(EV_COMMIT, row_addr, '0, '0);
              row_fill = 0;
              retries  = '0;
              // End check uses the unwrapped reach of the next row
              reach    = 32'(row_addr) + 2 * ADDR_STEP - 1;
              row_addr = row_addr + ADDR_W'(ADDR_STEP);
              if (reach > cfg_end_addr) begin
                expect_result(EV_END, '0, '0, '0);
                load_phase = PH_DONE;
              end else begin
                expect_result(EV_ACK, '0, '0, '0);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (expected_results.size() > queued) begin
      expected_results[expected_results.size() - 1].last = 1'b1;
    end
  endfunction

  // Send one item; hold it until the transfer, with an optional gap before it.
  task automatic send_item(logic op, logic [BYTE_W-1:0] b);
    int unsigned gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 9);
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.opcode  <= op;
    item_ch.rx_byte <= b;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    predict_item(op, b);
  endtask

  // Write a register once the sequencer has settled.
  task automatic write_register(sfl_cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    // Let an item that caused no result finish inside the block
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_BYTE_TIMEOUT: cfg_byte_timeout = value;
      CFG_HS_TIMEOUT:   cfg_hs_timeout   = value;
      CFG_START_ADDR:   cfg_start_addr   = value;
      CFG_END_ADDR:     cfg_end_addr     = value;
      CFG_RETRY_LIMIT:  cfg_retry_limit  = value[RETRY_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Send data bytes, with short silences that stay under the byte timeout.
  task automatic send_row_bytes(int unsigned count);
    int unsigned quiet;
    repeat (count) begin
      if ($urandom_range(0, 5) == 0 && gap_ticks < cfg_byte_timeout) begin
        quiet = $urandom_range(1, cfg_byte_timeout - gap_ticks);
        if (quiet > 8) begin
          quiet = 8;
        end
        repeat (quiet) send_item(OP_TICK, 8'($urandom));
      end
      send_item(OP_BYTE, 8'($urandom));
    end
  endtask

  // Keep ticking until the packet timeout fires.
  task automatic run_to_timeout();
    logic fired;
    do begin
      fired = (gap_ticks >= cfg_byte_timeout);
      send_item(OP_TICK, 8'($urandom));
    end while (!fired);
  endtask

  // Start pair search: stray bytes, tick counting, lowered timeout, then the pair.
  task automatic test_handshake_search();
    logic [ADDR_W-1:0] load_base;
    idling_on = 1'b1;
    // Park the load registers at extremes that the search does not use
    write_register(CFG_RETRY_LIMIT, 24'd1);
    write_register(CFG_START_ADDR, 24'hFFFFFF);
    write_register(CFG_END_ADDR, 24'd0);
    // Shortest timeout: bytes alone must never trip it
    write_register(CFG_HS_TIMEOUT, 24'd1);
    send_item(OP_BYTE, SYNC_SECOND);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, SYNC_FIRST);
    send_item(OP_BYTE, SYNC_FIRST);
    send_item(OP_BYTE, 8'h5A);
    write_register(CFG_HS_TIMEOUT, 24'hFFFFFF);
    repeat (5) send_item(OP_TICK, 8'($urandom));
    // Leave two ticks of slack, then use one of them inside the pair
    write_register(CFG_HS_TIMEOUT, hs_ticks + 24'd4);
    repeat (2) send_item(OP_TICK, 8'($urandom));
    load_base = $urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(0, 24'h7FFFFF));
    write_register(CFG_START_ADDR, load_base);
    write_register(CFG_END_ADDR, 24'hFFFFFF);
    write_register(CFG_RETRY_LIMIT, 24'd15);
    write_register(CFG_BYTE_TIMEOUT, 24'hFFFFFF);
    // A tick between the two bytes keeps the first one
    send_item(OP_BYTE, SYNC_FIRST);
    send_item(OP_TICK, 8'($urandom));
    send_item(OP_BYTE, SYNC_SECOND);
  endtask

  // Byte pairing, lowered byte timeout, and a discarded odd byte.
  task automatic test_word_packing();
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    repeat (2) send_item(OP_TICK, 8'($urandom));
    // The idle count already exceeds the new limit: next tick times out
    write_register(CFG_BYTE_TIMEOUT, 24'd1);
    send_item(OP_TICK, 8'($urandom));
    send_item(OP_BYTE, 8'($urandom));
    repeat (2) send_item(OP_TICK, 8'($urandom));
    write_register(CFG_BYTE_TIMEOUT, 24'd3);
    repeat (2) send_item(OP_BYTE, 8'($urandom));
  endtask

  // Full rows mixed with rows cut short by silence.
  task automatic test_random_load();
    int unsigned first_item;
    first_item = items_sent;
    idling_on  = 1'b1;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        write_register(CFG_BYTE_TIMEOUT, 24'($urandom_range(1, 6)));
      end
      if (items_sent != first_item && retries + 1 < cfg_retry_limit &&
          $urandom_range(0, 2) != 0) begin
        send_row_bytes($urandom_range(1, 40));
        run_to_timeout();
      end else begin
        // Either the next row reaches exactly the end address, or far below it
        write_register(CFG_END_ADDR, $urandom_range(0, 1) ? row_addr + 24'd255 : 24'hFFFFFF);
        send_row_bytes(ROW_BYTES - row_fill);
      end
    end
  endtask

  // Finish the load by end of region or by exhausted retries, then stay silent.
  task automatic test_load_finish();
    idling_on = 1'b0;
    if ($urandom_range(0, 1)) begin
      write_register(CFG_END_ADDR, $urandom_range(0, 1) ? 24'd0 : row_addr + 24'd254);
      send_row_bytes(ROW_BYTES - row_fill);
    end else begin
      write_register(CFG_RETRY_LIMIT, 24'd1);
      send_row_bytes($urandom_range(0, 5));
      run_to_timeout();
    end
    repeat (8) send_item(1'($urandom), 8'($urandom));
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    load_result_t want;
    if (result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, event_code %0d",
                                  result_ch.event_code));
      end else begin
        want = expected_results.pop_front();
        if (result_ch.event_code !== want.ev)
          report_mismatch($sformatf("event_code %0d, expected %0d",
                                    result_ch.event_code, want.ev));
        if (result_ch.row_address !== want.addr)
          report_mismatch($sformatf("row_address %h, expected %h (event %0d)",
                                    result_ch.row_address, want.addr, want.ev));
        if (result_ch.word_index !== want.widx)
          report_mismatch($sformatf("word_index %0d, expected %0d (event %0d)",
                                    result_ch.word_index, want.widx, want.ev));
        if (result_ch.data_word !== want.word)
          report_mismatch($sformatf("data_word %h, expected %h (event %0d)",
                                    result_ch.data_word, want.word, want.ev));
        if (result_ch.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b (event %0d)",
                                    result_ch.last, want.last, want.ev));
      end
    end
  end

  // Result ready: stall in random bursts while idling is on
  initial begin : drive_result_ready
    int unsigned hold;
    hold = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 9) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    item_ch.valid   <= 1'b0;
    item_ch.opcode  <= OP_TICK;
    item_ch.rx_byte <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_BYTE_TIMEOUT;
    cfg_ch.data     <= '0;
    // Hold reset, then release it on a falling edge
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_handshake_search();
    test_word_packing();
    test_random_load();
    test_load_finish();

    // Drop the item channel and drain what is still owed
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/sfl_pkg.sv
hdl/sfl_if.sv
hdl/sfl_core.sv
hdl/sfl_out_queue.sv
hdl/serial_firmware_load_sequencer.sv
hdl/sfl_checker.sv
test/serial_firmware_load_sequencer_tb.sv
